>>> rtl/pec_pkg.sv
package pec_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int SYM_W       = 8;
  localparam int ITER_W      = $clog2(DATA_W);
  localparam int OUT_W       = ((DATA_W + 3 + 7) / 8) * 8;

  localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;
  localparam logic [SYM_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [SYM_W-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [SYM_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [SYM_W-1:0] CH_LO_Z  = 8'h7A;
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [SYM_W-1:0] CH_CARET = 8'h5E;

  localparam logic [DATA_W-1:0] INEXACT_VALUE = 32'hFFFE_7961;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_INEXACT   = 3'd1,
    ERR_DIVZERO   = 3'd2,
    ERR_UNDERFLOW = 3'd3,
    ERR_OVERFLOW  = 3'd4
  } err_t;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_POW
  } op_kind_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_PUSH,
    DP_READ,
    DP_RESULT,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_POW_INIT,
    DP_POW_STEP,
    DP_ERROR,
    DP_EMIT
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_EXEC,
    S_DIV,
    S_DIV_FIN,
    S_POW,
    S_END
  } state_t;

  typedef struct packed {
    dp_op_t op;
    err_t   err;
  } dp_cmd_t;

  typedef struct packed {
    logic     is_operand;
    logic     is_operator;
    op_kind_t op_kind;
    logic     err_set;
    logic     full;
    logic     below_two;
    logic     rhs_zero;
    logic     inexact;
    logic     exp_zero;
    logic     out_busy;
  } dp_stat_t;

  function automatic logic is_operand_char(input logic [SYM_W-1:0] ch);
    return (ch >= CH_ZERO && ch <= CH_NINE) || (ch >= CH_UP_A && ch <= CH_UP_Z) ||
           (ch >= CH_LO_A && ch <= CH_LO_Z);
  endfunction

endpackage

>>> rtl/pec_ctrl.sv
module pec_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic              s_tlast,
  input  pec_pkg::dp_stat_t stat,
  output pec_pkg::dp_cmd_t  cmd
);

  pec_pkg::state_t                 state, state_next;
  logic                            last_item, last_item_next;
  logic [pec_pkg::ITER_W-1:0]      step, step_next;
  pec_pkg::state_t                 done_state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pec_pkg::S_IDLE;
      last_item <= 1'b0;
      step      <= '0;
    end else begin
      state     <= state_next;
      last_item <= last_item_next;
      step      <= step_next;
    end
  end

  assign done_state = last_item ? pec_pkg::S_END : pec_pkg::S_IDLE;

  always_comb begin
    state_next     = state;
    last_item_next = last_item;
    step_next      = step;
    cmd.op         = pec_pkg::DP_NOP;
    cmd.err        = pec_pkg::ERR_NONE;
    s_tready       = 1'b0;
    unique case (state)
      pec_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.op         = pec_pkg::DP_LOAD;
          last_item_next = s_tlast;
          state_next     = pec_pkg::S_DECODE;
        end
      end
      pec_pkg::S_DECODE: begin
        state_next = done_state;
        if (!stat.err_set) begin
          if (stat.is_operand) begin
            if (stat.full) begin
              cmd.op  = pec_pkg::DP_ERROR;
              cmd.err = pec_pkg::ERR_OVERFLOW;
            end else begin
              cmd.op = pec_pkg::DP_PUSH;
            end
          end else if (stat.is_operator) begin
            if (stat.below_two) begin
              cmd.op  = pec_pkg::DP_ERROR;
              cmd.err = pec_pkg::ERR_UNDERFLOW;
            end else begin
              cmd.op     = pec_pkg::DP_READ;
              state_next = pec_pkg::S_EXEC;
            end
          end
        end
      end
      pec_pkg::S_EXEC: begin
        unique case (stat.op_kind)
          pec_pkg::OP_DIV: begin
            if (stat.rhs_zero) begin
              cmd.op     = pec_pkg::DP_ERROR;
              cmd.err    = pec_pkg::ERR_DIVZERO;
              state_next = done_state;
            end else begin
              cmd.op     = pec_pkg::DP_DIV_INIT;
              step_next  = '0;
              state_next = pec_pkg::S_DIV;
            end
          end
          pec_pkg::OP_POW: begin
            cmd.op     = pec_pkg::DP_POW_INIT;
            state_next = pec_pkg::S_POW;
          end
          default: begin
            cmd.op     = pec_pkg::DP_RESULT;
            state_next = done_state;
          end
        endcase
      end
      pec_pkg::S_DIV: begin
        cmd.op    = pec_pkg::DP_DIV_STEP;
        step_next = step + 1'b1;
        if (step == pec_pkg::ITER_W'(pec_pkg::DATA_W - 1)) begin
          state_next = pec_pkg::S_DIV_FIN;
        end
      end
      pec_pkg::S_DIV_FIN: begin
        state_next = done_state;
        if (stat.inexact) begin
          cmd.op  = pec_pkg::DP_ERROR;
          cmd.err = pec_pkg::ERR_INEXACT;
        end else begin
          cmd.op = pec_pkg::DP_RESULT;
        end
      end
      pec_pkg::S_POW: begin
        if (stat.exp_zero) begin
          cmd.op     = pec_pkg::DP_RESULT;
          state_next = done_state;
        end else begin
          cmd.op = pec_pkg::DP_POW_STEP;
        end
      end
      pec_pkg::S_END: begin
        if (!stat.out_busy) begin
          cmd.op     = pec_pkg::DP_EMIT;
          state_next = pec_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pec_pkg::S_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == pec_pkg::S_DIV_FIN) |-> ($past(state, 33) == pec_pkg::S_EXEC))
    else $error("divide did not run the full bit count");
  a_emit_only_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == pec_pkg::DP_EMIT) |-> last_item)
    else $error("emit without end of expression");
  a_load_from_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == pec_pkg::DP_LOAD) |=> (state == pec_pkg::S_DECODE))
    else $error("load did not lead to decode");
`endif

endmodule

>>> rtl/pec_dp.sv
module pec_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [pec_pkg::SYM_W-1:0]        symbol_in,
  input  pec_pkg::dp_cmd_t                 cmd,
  output pec_pkg::dp_stat_t                stat,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [pec_pkg::OUT_W-1:0]        m_tdata
);

  logic [pec_pkg::DATA_W-1:0]  stack_mem [pec_pkg::STACK_DEPTH];
  logic [pec_pkg::COUNT_W-1:0] count;
  pec_pkg::err_t               err;
  logic [pec_pkg::SYM_W-1:0]   sym;
  logic [pec_pkg::DATA_W-1:0]  tos;
  logic [pec_pkg::DATA_W-1:0]  lhs;
  logic [pec_pkg::DATA_W-1:0]  rem;
  logic [pec_pkg::DATA_W-1:0]  quo;
  logic [pec_pkg::DATA_W-1:0]  dvs;
  logic                        dneg;
  logic [pec_pkg::DATA_W-1:0]  pres;
  logic [pec_pkg::DATA_W-1:0]  pbase;
  logic [pec_pkg::DATA_W-1:0]  pexp;
  logic [pec_pkg::DATA_W-1:0]  out_value;
  pec_pkg::err_t               out_err;
  logic                        out_valid;

  logic [pec_pkg::COUNT_W-1:0] cnt_m1, cnt_m2;
  logic [pec_pkg::DATA_W:0]    div_trial;
  logic                        div_bit;
  logic [pec_pkg::DATA_W-1:0]  result;
  logic [pec_pkg::DATA_W-1:0]  pow_neg;
  pec_pkg::op_kind_t           op_kind;
  pec_pkg::err_t               final_err;
  logic [pec_pkg::DATA_W-1:0]  final_value;

  assign cnt_m1 = count - 1'b1;
  assign cnt_m2 = count - 2'd2;

  always_comb begin
    unique case (sym)
      pec_pkg::CH_PLUS:  op_kind = pec_pkg::OP_ADD;
      pec_pkg::CH_MINUS: op_kind = pec_pkg::OP_SUB;
      pec_pkg::CH_SLASH: op_kind = pec_pkg::OP_DIV;
      pec_pkg::CH_CARET: op_kind = pec_pkg::OP_POW;
      default:           op_kind = pec_pkg::OP_MUL;
    endcase
  end

  assign div_trial = {rem, quo[pec_pkg::DATA_W-1]};
  assign div_bit   = (div_trial >= {1'b0, dvs});

  always_comb begin
    unique case (op_kind)
      pec_pkg::OP_ADD: result = lhs + tos;
      pec_pkg::OP_SUB: result = lhs - tos;
      pec_pkg::OP_MUL: result = lhs * tos;
      pec_pkg::OP_DIV: result = dneg ? (~quo + 1'b1) : quo;
      pec_pkg::OP_POW: result = pres;
      default:         result = lhs * tos;
    endcase
  end

  always_comb begin
    if (lhs == pec_pkg::DATA_W'(1)) begin
      pow_neg = pec_pkg::DATA_W'(1);
    end else if (&lhs) begin
      pow_neg = tos[0] ? '1 : pec_pkg::DATA_W'(1);
    end else begin
      pow_neg = '0;
    end
  end

  always_comb begin
    if (err != pec_pkg::ERR_NONE) begin
      final_err = err;
    end else if (count == '0) begin
      final_err = pec_pkg::ERR_UNDERFLOW;
    end else begin
      final_err = pec_pkg::ERR_NONE;
    end
    if (final_err == pec_pkg::ERR_INEXACT) begin
      final_value = pec_pkg::INEXACT_VALUE;
    end else if (final_err != pec_pkg::ERR_NONE) begin
      final_value = '0;
    end else begin
      final_value = tos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      err       <= pec_pkg::ERR_NONE;
      out_valid <= 1'b0;
    end else begin
      if (m_tready && cmd.op != pec_pkg::DP_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (cmd.op)
        pec_pkg::DP_PUSH:   count <= count + 1'b1;
        pec_pkg::DP_RESULT: count <= cnt_m1;
        pec_pkg::DP_ERROR:  err   <= cmd.err;
        pec_pkg::DP_EMIT: begin
          count     <= '0;
          err       <= pec_pkg::ERR_NONE;
          out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == pec_pkg::DP_PUSH && count != '0) begin
      stack_mem[cnt_m1[pec_pkg::PTR_W-1:0]] <= tos;
    end
    if (cmd.op == pec_pkg::DP_READ) begin
      lhs <= stack_mem[cnt_m2[pec_pkg::PTR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      pec_pkg::DP_LOAD:   sym <= symbol_in;
      pec_pkg::DP_PUSH:   tos <= pec_pkg::DATA_W'(sym) - pec_pkg::DATA_W'(pec_pkg::CH_ZERO);
      pec_pkg::DP_RESULT: tos <= result;
      pec_pkg::DP_DIV_INIT: begin
        rem  <= '0;
        quo  <= lhs[pec_pkg::DATA_W-1] ? (~lhs + 1'b1) : lhs;
        dvs  <= tos[pec_pkg::DATA_W-1] ? (~tos + 1'b1) : tos;
        dneg <= lhs[pec_pkg::DATA_W-1] ^ tos[pec_pkg::DATA_W-1];
      end
      pec_pkg::DP_DIV_STEP: begin
        rem <= div_bit ? pec_pkg::DATA_W'(div_trial - {1'b0, dvs})
                       : div_trial[pec_pkg::DATA_W-1:0];
        quo <= {quo[pec_pkg::DATA_W-2:0], div_bit};
      end
      pec_pkg::DP_POW_INIT: begin
        pbase <= lhs;
        if (tos[pec_pkg::DATA_W-1]) begin
          pres <= pow_neg;
          pexp <= '0;
        end else begin
          pres <= pec_pkg::DATA_W'(1);
          pexp <= tos;
        end
      end
      pec_pkg::DP_POW_STEP: begin
        if (pexp[0]) begin
          pres <= pres * pbase;
        end
        pbase <= pbase * pbase;
        pexp  <= pexp >> 1;
      end
      pec_pkg::DP_EMIT: begin
        out_value <= final_value;
        out_err   <= final_err;
      end
      default: ;
    endcase
  end

  assign stat.is_operand  = pec_pkg::is_operand_char(sym);
  assign stat.is_operator = (sym == pec_pkg::CH_PLUS) || (sym == pec_pkg::CH_MINUS) ||
                            (sym == pec_pkg::CH_STAR) || (sym == pec_pkg::CH_SLASH) ||
                            (sym == pec_pkg::CH_CARET);
  assign stat.op_kind     = op_kind;
  assign stat.err_set     = (err != pec_pkg::ERR_NONE);
  assign stat.full        = (count >= pec_pkg::COUNT_W'(pec_pkg::STACK_DEPTH));
  assign stat.below_two   = (count < pec_pkg::COUNT_W'(2));
  assign stat.rhs_zero    = (tos == '0);
  assign stat.inexact     = (rem != '0);
  assign stat.exp_zero    = (pexp == '0);
  assign stat.out_busy    = out_valid && !m_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(pec_pkg::OUT_W - pec_pkg::DATA_W - 3){1'b0}}, out_err, out_value};

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= pec_pkg::COUNT_W'(pec_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == pec_pkg::DP_PUSH) |=> (count == $past(count) + 1'b1))
    else $error("push did not grow the stack");
  a_no_work_on_error: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == pec_pkg::DP_PUSH || cmd.op == pec_pkg::DP_READ) |-> (err == pec_pkg::ERR_NONE))
    else $error("stack touched after error");
  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == pec_pkg::DP_EMIT) |=> (count == '0 && err == pec_pkg::ERR_NONE && out_valid))
    else $error("end of expression did not clear state");
`endif

endmodule

>>> rtl/postfix_expression_evaluator.sv
// Postfix expression evaluator.
// Input stream: one character per beat. s_tdata[7:0] is the symbol, s_tlast
// marks the final character of an expression. Digits and letters push their
// code minus 48; + - * / ^ pop two operands and push the result; other bytes
// are ignored.
// Output stream: one beat per expression, after the beat marked s_tlast.
// m_tdata[31:0] is the value, m_tdata[34:32] the error code.
// Work per input beat: a push, an ignored byte or a stack error ends there;
// + - * write the result; / runs a 32-step restoring divider (skipped when the
// divisor is zero); ^ runs one square-and-multiply step per exponent bit until
// the exponent runs out. A last beat also loads the output register.
// Only one character is worked on at a time; s_tready is high while the
// block waits for the next beat.
// The result sits in an output register; while m_tready is low the block
// keeps taking characters and stalls only when a second result is ready.
// Reset empties the stack and clears the error and the output valid flag.
module postfix_expression_evaluator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [pec_pkg::SYM_W-1:0]    s_tdata,  // [7:0] symbol
  input  logic                         s_tlast,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [pec_pkg::OUT_W-1:0]    m_tdata   // [31:0] value, [34:32] error_code
);

  pec_pkg::dp_cmd_t  cmd;
  pec_pkg::dp_stat_t stat;

  pec_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .stat     (stat),
    .cmd      (cmd)
  );

  pec_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .symbol_in (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
